/* hw/rtl/sqe_pkg.sv */
package sqe_pkg;

  // Record kinds carried on the result channel.
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  // Each sprite expands into four vertex records, then six index records.
  localparam int unsigned VERTEX_RECORDS = 4;
  localparam int unsigned INDEX_RECORDS  = 6;
  localparam int unsigned SPRITE_RECORDS = VERTEX_RECORDS + INDEX_RECORDS;
  localparam int unsigned STEP_W         = $clog2(SPRITE_RECORDS);

  localparam logic [STEP_W-1:0] FIRST_INDEX_STEP = STEP_W'(VERTEX_RECORDS);
  localparam logic [STEP_W-1:0] LAST_STEP        = STEP_W'(SPRITE_RECORDS - 1);

  // Vertex steps, in emission order: corners (-,-), (+,-), (+,+), (-,+).
  localparam logic [STEP_W-1:0] STEP_CORNER_MM = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_CORNER_PM = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_CORNER_PP = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_CORNER_MP = STEP_W'(3);

  localparam logic [31:0] VERTEX_STRIDE = 32'd4;

  typedef struct packed {
    logic signed [31:0] axis_u_x;
    logic signed [31:0] axis_u_y;
    logic signed [31:0] axis_u_z;
    logic signed [31:0] axis_v_x;
    logic signed [31:0] axis_v_y;
    logic signed [31:0] axis_v_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [63:0]        tex_rect;
    logic [31:0]        tint_color;
  } sprite_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [31:0]        index_value;
    logic               last_of_sprite;
  } record_t;

  // Triangle list offsets 0,1,2,2,3,0 for the six index steps.
  function automatic logic [1:0] index_offset(input logic [STEP_W-1:0] step);
    logic [1:0] off;
    off = 2'd0;
    case (step)
      STEP_W'(5): off = 2'd1;
      STEP_W'(6): off = 2'd2;
      STEP_W'(7): off = 2'd2;
      STEP_W'(8): off = 2'd3;
      default:    off = 2'd0;
    endcase
    return off;
  endfunction

endpackage

/* hw/rtl/sqe_corner_calc.sv */
module sqe_corner_calc (
  input  logic signed [31:0] origin,
  input  logic signed [31:0] axis_a,
  input  logic signed [31:0] axis_b,
  input  logic               neg_a,
  input  logic               neg_b,
  output logic signed [31:0] coord
);

  logic signed [34:0] origin2;
  logic signed [34:0] term_a;
  logic signed [34:0] term_b;
  logic signed [34:0] sum;
  logic signed [33:0] half;

  // Exact sum of 2*origin +- a +- b, then floor halving by dropping bit 0 and saturation to the 32-bit signed range.
  always_comb begin
    origin2 = {{2{origin[31]}}, origin, 1'b0};
    term_a  = {{3{axis_a[31]}}, axis_a};
    term_b  = {{3{axis_b[31]}}, axis_b};
    sum     = origin2 + (neg_a ? -term_a : term_a) + (neg_b ? -term_b : term_b);
    half    = sum[34:1];
    if ((half[33:31] == 3'b000) || (half[33:31] == 3'b111)) begin
      coord = half[31:0];
    end else if (half[33]) begin
      coord = 32'sh8000_0000;
    end else begin
      coord = 32'sh7FFF_FFFF;
    end
  end

endmodule

/* hw/rtl/sqe_record_gen.sv */
module sqe_record_gen (
  input  sqe_pkg::sprite_t             sprite,
  input  logic [31:0]                  base,
  input  logic [sqe_pkg::STEP_W-1:0]   step,
  output sqe_pkg::record_t             rec
);
  import sqe_pkg::*;

  logic               neg_u;
  logic               neg_v;
  logic               hi_u;
  logic               hi_v;
  logic               is_vertex;
  logic [16:0]        u1_sum;
  logic [16:0]        v1_sum;
  logic [15:0]        u0;
  logic [15:0]        v0;
  logic [15:0]        u1;
  logic [15:0]        v1;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;

  always_comb begin
    is_vertex = (step < FIRST_INDEX_STEP);
    neg_u     = (step == STEP_CORNER_MM) || (step == STEP_CORNER_MP);
    neg_v     = (step == STEP_CORNER_MM) || (step == STEP_CORNER_PM);
    hi_u      = (step == STEP_CORNER_PM) || (step == STEP_CORNER_PP);
    hi_v      = neg_v;
  end

  sqe_corner_calc u_corner_x (
    .origin (sprite.origin_x),
    .axis_a (sprite.axis_u_x),
    .axis_b (sprite.axis_v_x),
    .neg_a  (neg_u),
    .neg_b  (neg_v),
    .coord  (cx)
  );

  sqe_corner_calc u_corner_y (
    .origin (sprite.origin_y),
    .axis_a (sprite.axis_u_y),
    .axis_b (sprite.axis_v_y),
    .neg_a  (neg_u),
    .neg_b  (neg_v),
    .coord  (cy)
  );

  sqe_corner_calc u_corner_z (
    .origin (sprite.origin_z),
    .axis_a (sprite.axis_u_z),
    .axis_b (sprite.axis_v_z),
    .neg_a  (neg_u),
    .neg_b  (neg_v),
    .coord  (cz)
  );

  // Far texture edges saturate at the top of the Q4.12 range.
  always_comb begin
    u0     = sprite.tex_rect[15:0];
    v0     = sprite.tex_rect[31:16];
    u1_sum = {1'b0, u0} + {1'b0, sprite.tex_rect[47:32]};
    v1_sum = {1'b0, v0} + {1'b0, sprite.tex_rect[63:48]};
    u1     = u1_sum[16] ? 16'hFFFF : u1_sum[15:0];
    v1     = v1_sum[16] ? 16'hFFFF : v1_sum[15:0];
  end

  always_comb begin
    rec                = '0;
    rec.last_of_sprite = (step == LAST_STEP);
    if (is_vertex) begin
      rec.kind         = KIND_VERTEX;
      rec.pos_x        = cx;
      rec.pos_y        = cy;
      rec.pos_z        = cz;
      rec.tex_u        = hi_u ? u1 : u0;
      rec.tex_v        = hi_v ? v1 : v0;
      rec.vertex_color = sprite.tint_color;
    end else begin
      rec.kind        = KIND_INDEX;
      rec.index_value = base + {30'd0, index_offset(step)};
    end
  end

endmodule

/* hw/rtl/sprite_quad_expander_core.sv */
// Channel  Direction  Beat contents
// in_*     slave      tdata: one sprite (transform, texture rectangle, color);
//                     tuser: batch_start
// out_*    master     tdata: one vertex or index record; tuser: kind;
//                     tlast: last_of_sprite
//
// Every sprite yields ten output beats, one per cycle while out_tready is
// high; the step counter of the record sequencer sets the beat count. Input
// and output overlap: the next sprite is taken in the same cycle its
// predecessor's final record is loaded into the output register. Reset
// (rst_n low, synchronous) empties both registers and zeroes the running
// vertex count. A stall on out_tready freezes the sequencer and, once a
// sprite is waiting, in_tready too.
module sprite_quad_expander_core (
  input  logic         clk,
  input  logic         rst_n,
  // Fields from bit 0 up: axis_u_x, axis_u_y, axis_u_z, axis_v_x, axis_v_y,
  // axis_v_z, origin_x, origin_y, origin_z, tex_rect, tint_color.
  input  logic [383:0] in_tdata,
  input  logic         in_tuser,   // batch_start
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0 up: pos_x, pos_y, pos_z, tex_u, tex_v, vertex_color,
  // index_value.
  output logic [191:0] out_tdata,
  output logic         out_tuser,  // kind
  output logic         out_tlast,  // last_of_sprite
  output logic         out_tvalid,
  input  logic         out_tready
);
  import sqe_pkg::*;

  // Sprite holding register and its sequencer.
  sprite_t           sprite_r;
  logic [31:0]       base_r;
  logic              hold_valid_r;
  logic              hold_valid_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  // Running vertex count; it already includes the sprite being expanded.
  logic [31:0]       count_r;
  logic [31:0]       base_nxt;

  // Output register.
  record_t           rec_nxt;
  record_t           out_rec_r;
  logic              out_valid_r;
  logic              out_valid_nxt;

  logic              advance;
  logic              finishing;
  logic              in_fire;

  // A record moves into the output register whenever a sprite is held and
  // that register is empty or its current beat is being taken.
  assign advance   = hold_valid_r && (!out_valid_r || out_tready);
  assign finishing = advance && (step_r == LAST_STEP);
  assign in_tready = !hold_valid_r || finishing;
  assign in_fire   = in_tvalid && in_tready;
  assign base_nxt  = in_tuser ? 32'd0 : count_r;

  sqe_record_gen u_record_gen (
    .sprite (sprite_r),
    .base   (base_r),
    .step   (step_r),
    .rec    (rec_nxt)
  );

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    step_nxt       = step_r;
    if (advance) begin
      step_nxt = step_r + STEP_W'(1);
    end
    if (finishing) begin
      hold_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      hold_valid_nxt = 1'b1;
      step_nxt       = '0;
    end
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      step_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
      if (in_fire) begin
        count_r <= base_nxt + VERTEX_STRIDE;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sprite_r.axis_u_x   <= in_tdata[31:0];
      sprite_r.axis_u_y   <= in_tdata[63:32];
      sprite_r.axis_u_z   <= in_tdata[95:64];
      sprite_r.axis_v_x   <= in_tdata[127:96];
      sprite_r.axis_v_y   <= in_tdata[159:128];
      sprite_r.axis_v_z   <= in_tdata[191:160];
      sprite_r.origin_x   <= in_tdata[223:192];
      sprite_r.origin_y   <= in_tdata[255:224];
      sprite_r.origin_z   <= in_tdata[287:256];
      sprite_r.tex_rect   <= in_tdata[351:288];
      sprite_r.tint_color <= in_tdata[383:352];
      base_r              <= base_nxt;
    end
    if (advance) begin
      out_rec_r <= rec_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rec_r.kind;
  assign out_tlast  = out_rec_r.last_of_sprite;
  assign out_tdata  = {out_rec_r.index_value, out_rec_r.vertex_color,
                       out_rec_r.tex_v, out_rec_r.tex_u,
                       out_rec_r.pos_z, out_rec_r.pos_y, out_rec_r.pos_x};

endmodule
